// ----- rtl/pxgray_pkg.sv -----
package pxgray_pkg;

   localparam int unsigned PIX_W            = 8;
   localparam int unsigned MODE_W           = 2;
   localparam int unsigned GAMMA_INDEX_BITS = 12;
   localparam int unsigned COEF_FRAC_BITS   = 16;
   // the gamma table is folded into rows of consecutive entries
   localparam int unsigned ROW_SEL_BITS     = 7;
   // wide enough for both sides of the gamma threshold compare
   localparam int unsigned BIG_W            = 384;

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS   = 2'd0,
      MODE_INVERT = 2'd1,
      MODE_GRAY   = 2'd2
   } mode_type;

   function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base,
                                                input int unsigned      n);
      logic [BIG_W-1:0] acc;
      acc = BIG_W'(1);
      for (int unsigned k = 0; k < n; k++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

   // code v is reached once yv^5 * 269025^12 >= (1000v + 14025)^12 * (255 << c)^5
   function automatic logic gamma_reaches(input longint unsigned yv,
                                          input int unsigned     code,
                                          input int unsigned     c_bits);
      logic [BIG_W-1:0] lhs;
      logic [BIG_W-1:0] rhs;
      lhs = big_pow(BIG_W'(yv), 5) * big_pow(BIG_W'(269025), 12);
      rhs = big_pow(BIG_W'(1000 * code + 14025), 12)
          * big_pow(BIG_W'(longint'(255) << c_bits), 5);
      return lhs >= rhs;
   endfunction

   // linear segment near black, y at or below 0.0031308
   function automatic logic gamma_is_linear(input longint unsigned yv,
                                            input int unsigned     c_bits);
      return yv * 64'd10000000 <= (longint'(31308 * 255) << c_bits);
   endfunction

   // trunc(12.92 * yv / 2^c), counted up instead of divided
   function automatic logic [PIX_W-1:0] gamma_linear(input longint unsigned yv,
                                                     input int unsigned     c_bits);
      longint unsigned lin;
      lin = 0;
      while (lin < 255 && (lin + 1) * (longint'(100) << c_bits) <= 64'd1292 * yv) begin
         lin++;
      end
      return PIX_W'(lin);
   endfunction

endpackage

// ----- rtl/pxgray_if.sv -----
interface pxgray_req_if;
   logic                          valid;
   logic                          ready;
   logic [pxgray_pkg::PIX_W-1:0]  red_in;
   logic [pxgray_pkg::PIX_W-1:0]  green_in;
   logic [pxgray_pkg::PIX_W-1:0]  blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface pxgray_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pxgray_pkg::PIX_W-1:0]  red_out;
   logic [pxgray_pkg::PIX_W-1:0]  green_out;
   logic [pxgray_pkg::PIX_W-1:0]  blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface pxgray_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pxgray_pkg::MODE_W-1:0] mode;

   modport source (output valid, mode, input ready);
   modport sink   (input valid, mode, output ready);
endinterface

// ----- rtl/pixel_invert_or_srgb_grayscale.sv -----
// an accepted item passes through the input register and then the result register before
// it is offered on the result side
// throughput: one item per cycle, sustained while the result side keeps ready high
// the rate is set by the single pass through the luma sum and gamma table lookup
// reset (synchronous, active high) empties both stages and sets mode to pass through
// configuration writes are always taken; mode applies to each item as it enters the result register
module pixel_invert_or_srgb_grayscale #(
   parameter int unsigned GAMMA_INDEX_BITS = pxgray_pkg::GAMMA_INDEX_BITS,
   parameter int unsigned COEF_FRAC_BITS   = pxgray_pkg::COEF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   pxgray_req_if.sink   req,
   pxgray_rsp_if.source rsp,
   pxgray_csr_if.sink   csr
);

   localparam int unsigned PIX_W     = pxgray_pkg::PIX_W;
   localparam int unsigned SUM_W     = COEF_FRAC_BITS + PIX_W;
   localparam int unsigned IDX_SHIFT = SUM_W - GAMMA_INDEX_BITS;
   localparam int unsigned ROW_SEL   = pxgray_pkg::ROW_SEL_BITS;
   localparam int unsigned ROWS      = 1 << ROW_SEL;
   // entries per table row come from the low index bits, 32 with the default widths
   localparam int unsigned SEG_W     = GAMMA_INDEX_BITS - ROW_SEL;
   localparam int unsigned SEG       = 1 << SEG_W;
   localparam int unsigned ROW_W     = SEG * PIX_W;

   // bt.709 luma weights in unsigned q.c, green takes the rounding slack
   localparam int unsigned K_RED   = int'(((longint'(2126) << COEF_FRAC_BITS) + 5000) / 10000);
   localparam int unsigned K_BLUE  = int'(((longint'(722) << COEF_FRAC_BITS) + 5000) / 10000);
   localparam int unsigned K_GREEN = (1 << COEF_FRAC_BITS) - K_RED - K_BLUE;

   typedef logic [ROWS-1:0][ROW_W-1:0] gamma_rows_type;

   // gamma table: row picked by the top index bits, entry by the low bits
   function automatic gamma_rows_type build_rows();
      gamma_rows_type   rows;
      longint unsigned  yv;
      int unsigned      code;
      logic [PIX_W-1:0] entry;
      code = 0;
      for (int r = 0; r < ROWS; r++) begin
         for (int s = 0; s < SEG; s++) begin
            yv = longint'(r * SEG + s) << IDX_SHIFT;
            // codes only rise along the table, the search goes on where it stopped
            while (code < 255 && pxgray_pkg::gamma_reaches(yv, code + 1, COEF_FRAC_BITS)) begin
               code++;
            end
            if (pxgray_pkg::gamma_is_linear(yv, COEF_FRAC_BITS)) begin
               entry = pxgray_pkg::gamma_linear(yv, COEF_FRAC_BITS);
            end else begin
               entry = PIX_W'(code);
            end
            rows[r][s*PIX_W +: PIX_W] = entry;
         end
      end
      return rows;
   endfunction

   localparam gamma_rows_type GAMMA_ROWS = build_rows();

   // mode register
   pxgray_pkg::mode_type mode_ff;

   // input stage
   logic             in_valid_ff;
   logic [PIX_W-1:0] red_ff;
   logic [PIX_W-1:0] green_ff;
   logic [PIX_W-1:0] blue_ff;

   // result stage
   logic             out_valid_ff;
   logic [PIX_W-1:0] red_out_ff;
   logic [PIX_W-1:0] green_out_ff;
   logic [PIX_W-1:0] blue_out_ff;
   logic [PIX_W-1:0] red_out_in;
   logic [PIX_W-1:0] green_out_in;
   logic [PIX_W-1:0] blue_out_in;

   logic                        out_load;
   logic                        in_load;
   logic [SUM_W-1:0]            luma_sum;
   logic [GAMMA_INDEX_BITS-1:0] gamma_idx;
   logic [ROW_W-1:0]            gamma_row;
   logic [PIX_W-1:0]            grey;

   // result register frees up when empty or being taken this cycle
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp.ready);
   // input register takes a new item when empty or moving forward
   assign in_load   = req.valid && req.ready;
   assign req.ready = !in_valid_ff || out_load;
   assign csr.ready = 1'b1;

   // weighted sum of the channels, exact in SUM_W bits
   assign luma_sum  = SUM_W'(K_RED)   * SUM_W'(red_ff)
                    + SUM_W'(K_GREEN) * SUM_W'(green_ff)
                    + SUM_W'(K_BLUE)  * SUM_W'(blue_ff);
   assign gamma_idx = luma_sum[SUM_W-1 -: GAMMA_INDEX_BITS];
   assign gamma_row = GAMMA_ROWS[gamma_idx[GAMMA_INDEX_BITS-1 -: ROW_SEL]];
   assign grey      = gamma_row[gamma_idx[SEG_W-1:0]*PIX_W +: PIX_W];

   always_comb begin
      case (mode_ff)
         pxgray_pkg::MODE_INVERT: begin
            red_out_in   = ~red_ff;
            green_out_in = ~green_ff;
            blue_out_in  = ~blue_ff;
         end
         pxgray_pkg::MODE_GRAY: begin
            red_out_in   = grey;
            green_out_in = grey;
            blue_out_in  = grey;
         end
         default: begin
            // pass through, the unused mode code behaves the same
            red_out_in   = red_ff;
            green_out_in = green_ff;
            blue_out_in  = blue_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pxgray_pkg::MODE_PASS;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            mode_ff <= pxgray_pkg::mode_type'(csr.mode);
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         red_ff   <= req.red_in;
         green_ff <= req.green_in;
         blue_ff  <= req.blue_in;
      end
      if (out_load) begin
         red_out_ff   <= red_out_in;
         green_out_ff <= green_out_in;
         blue_out_ff  <= blue_out_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.red_out   = red_out_ff;
   assign rsp.green_out = green_out_ff;
   assign rsp.blue_out  = blue_out_ff;

   // an item held in the input stage is not lost, and its red and blue channels stay unaltered
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(red_ff) && $stable(blue_ff))
      else $error("input stage item dropped or changed while stalled");

   // grayscale results carry the same value on all channels
   assert property (@(posedge clock) disable iff (reset)
      out_load && mode_ff == pxgray_pkg::MODE_GRAY |=>
         rsp.red_out == rsp.green_out && rsp.green_out == rsp.blue_out)
      else $error("grayscale channels differ");

   // invert mode complements the red and blue channels of the held pixel
   assert property (@(posedge clock) disable iff (reset)
      out_load && mode_ff == pxgray_pkg::MODE_INVERT |=>
         rsp.red_out == ~$past(red_ff) && rsp.blue_out == ~$past(blue_ff))
      else $error("invert result mismatch");

   // pass mode copies the red and green channels of the held pixel
   assert property (@(posedge clock) disable iff (reset)
      out_load && mode_ff == pxgray_pkg::MODE_PASS |=>
         rsp.red_out == $past(red_ff) && rsp.green_out == $past(green_ff))
      else $error("pass through result mismatch");

endmodule
